### hdl/transparent_pixel_color_bleed_defines.svh
// assertion helpers for the color bleed block
`ifndef TRANSPARENT_PIXEL_COLOR_BLEED_DEFINES_SVH
`define TRANSPARENT_PIXEL_COLOR_BLEED_DEFINES_SVH

// condition holds at every edge out of reset
`define TPCB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TPCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tpcb_pkg.sv
package tpcb_pkg;

  localparam int unsigned SUM_W = 11;
  localparam int unsigned QUOT_W = 8;
  localparam int unsigned PIX_W = 32;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned CFG_W_RESET = 1024;
  localparam int unsigned CFG_H_RESET = 1024;
  localparam int unsigned NB_CNT = 9;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_SUM    = 6'b000100,
    ST_DSTART = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_HOLD   = 6'b100000
  } state_e;

  // row and column step of each window tap, center last
  localparam logic signed [1:0] NB_DR [NB_CNT] = '{
    -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, 2'sd0
  };
  localparam logic signed [1:0] NB_DC [NB_CNT] = '{
    -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, 2'sd0
  };
  localparam logic [3:0] NB_CENTER = 4'd8;

  typedef struct packed {
    logic             vld;
    logic             incl;
    logic             center;
  } rd_tag_t;

endpackage

### hdl/tpcb_ring_mem.sv
module tpcb_ring_mem #(
  parameter int unsigned DEPTH = 8195,
  parameter int unsigned AW    = 14
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [tpcb_pkg::PIX_W-1:0]    wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [tpcb_pkg::PIX_W-1:0]    rdata_o
);

  logic [tpcb_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/tpcb_div.sv
module tpcb_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tpcb_pkg::SUM_W-1:0]    sum_i,
  input  logic [tpcb_pkg::SUM_W-1:0]    den_i,
  output logic                          busy_o,
  output logic [tpcb_pkg::QUOT_W-1:0]   quot_o
);

  localparam int unsigned NW = tpcb_pkg::SUM_W + tpcb_pkg::QUOT_W;

  logic [NW-1:0] rem_q, rem_d, num, trial;
  logic [tpcb_pkg::SUM_W-1:0] den_q;
  logic [2:0] step_q;
  logic busy_q, sat_q;
  logic [tpcb_pkg::QUOT_W-1:0] q_q, q_d;

  // 255*sum as shift and subtract
  assign num   = (NW'(sum_i) << tpcb_pkg::QUOT_W) - NW'(sum_i);
  assign trial = NW'(den_q) << step_q;

  always_comb begin
    rem_d = rem_q;
    q_d   = q_q;
    if (rem_q >= trial) begin
      rem_d = rem_q - trial;
      q_d[step_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= 3'd7;
    end else if (busy_q) begin
      step_q <= step_q - 3'd1;
      if (step_q == 3'd0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num;
      den_q <= den_i;
      q_q   <= '0;
      sat_q <= num >= (NW'(den_i) << tpcb_pkg::QUOT_W);
    end else if (busy_q) begin
      rem_q <= rem_d;
      q_q   <= q_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = sat_q ? '1 : q_q;

endmodule

### hdl/transparent_pixel_color_bleed.sv
// color bleed into transparent pixels over a 3x3 neighborhood
// - input channel (in_valid_i / in_ready_o): one transaction per raster pixel, kind_i
//   selects a pixel or a flush that drains one pending output
// - output channel (out_valid_o / out_ready_i): one finished pixel per position,
//   lagging the input by one row plus one pixel; flushes drain the last W+1
// - config port: cfg_we_i writes width, height or alpha threshold at once; a width
//   or height write restarts the frame and holds the input off in the cycle after it
// - an item that yields no result leaves the sequencer idle; an item that yields a result
//   runs through nine reads of the single-port-read pixel ring, a collect state, a
//   divider start state, eight steps of the restoring dividers plus a check that they are
//   done, and a hold state that loads the output register
// - output is registered: the next input is taken while a result waits, and the
//   block only stalls when a second result is ready before the first is taken
// - reset clears positions and control state; the ring needs no clearing pass because
//   only pixels of the current frame are ever summed or used
module transparent_pixel_color_bleed #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [7:0]                    red_in_i,
  input  logic [7:0]                    green_in_i,
  input  logic [7:0]                    blue_in_i,
  input  logic [7:0]                    alpha_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    red_out_o,
  output logic [7:0]                    green_out_o,
  output logic [7:0]                    blue_out_o,
  output logic [7:0]                    alpha_out_o,
  output logic                          changed_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [tpcb_pkg::CFG_W-1:0]    cfg_wdata_i
);

  `include "transparent_pixel_color_bleed_defines.svh"

  localparam int unsigned RING = 2 * MAX_WIDTH + 3;
  localparam int unsigned AW   = $clog2(RING);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned W_RST =
    (tpcb_pkg::CFG_W_RESET > MAX_WIDTH) ? MAX_WIDTH : tpcb_pkg::CFG_W_RESET;
  localparam int unsigned H_RST =
    (tpcb_pkg::CFG_H_RESET > MAX_HEIGHT) ? MAX_HEIGHT : tpcb_pkg::CFG_H_RESET;

  tpcb_pkg::state_e state_q, state_d;

  // configuration, sizes kept already clamped
  logic [WW-1:0] eff_w_q, w_clamp;
  logic [HW-1:0] eff_h_q, h_clamp;
  logic [7:0]    thr_q;
  logic [PW-1:0] wh_q;
  logic          settle_q;
  logic          size_wr;

  // frame positions and their ring addresses
  logic [PW-1:0] in_pos_q, out_pos_q, pdiff;
  logic [AW-1:0] in_addr_q, out_addr_q;
  logic [WW-1:0] out_col_q;
  logic [HW-1:0] out_row_q;

  logic in_acc, take_pix, emit, out_ld, frame_end;
  logic [3:0] rd_k_q;
  tpcb_pkg::rd_tag_t tag_q, tag_d;

  logic [AW-1:0] rd_addr;
  logic [tpcb_pkg::PIX_W-1:0] rdata, ctr_q;
  logic [tpcb_pkg::SUM_W-1:0] sr_q, sg_q, sb_q, sa_q;
  logic [2:0] div_busy;
  logic [7:0] qr, qg, qb;
  logic       chg;

  logic out_valid_q;

  // clamp of size writes
  always_comb begin
    if (cfg_wdata_i == '0) begin
      w_clamp = WW'(1);
    end else if (32'(cfg_wdata_i) > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(cfg_wdata_i);
    end
    if (cfg_wdata_i == '0) begin
      h_clamp = HW'(1);
    end else if (32'(cfg_wdata_i) > MAX_HEIGHT) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(cfg_wdata_i);
    end
  end

  assign size_wr = cfg_we_i && (cfg_index_i == tpcb_pkg::CFG_WIDTH ||
                                cfg_index_i == tpcb_pkg::CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q  <= WW'(W_RST);
      eff_h_q  <= HW'(H_RST);
      thr_q    <= '0;
      wh_q     <= PW'(W_RST * H_RST);
      settle_q <= 1'b0;
    end else begin
      // frame size product is registered from the stored sizes, behind a size write
      wh_q     <= PW'(eff_w_q) * PW'(eff_h_q);
      settle_q <= size_wr;
      if (cfg_we_i) begin
        case (cfg_index_i)
          tpcb_pkg::CFG_WIDTH:  eff_w_q <= w_clamp;
          tpcb_pkg::CFG_HEIGHT: eff_h_q <= h_clamp;
          tpcb_pkg::CFG_THRESH: thr_q   <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // input side
  assign in_ready_o = (state_q == tpcb_pkg::ST_IDLE) && !settle_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign take_pix   = in_acc && (kind_i == tpcb_pkg::KIND_PIXEL) && (in_pos_q < wh_q);
  assign pdiff      = in_pos_q - out_pos_q;

  always_comb begin
    if (take_pix) begin
      // a full window of look-ahead is in once the input leads by a row plus one
      emit = (PW + 1)'(pdiff) >= (PW + 1)'(eff_w_q) + (PW + 1)'(1);
    end else begin
      emit = in_acc && (out_pos_q < in_pos_q);
    end
  end

  // neighbor address and in-image test for the tap being read
  logic signed [AW+1:0] w_s, off, a_sum;
  logic signed [1:0] dr, dc;
  logic incl;

  always_comb begin
    dr  = tpcb_pkg::NB_DR[rd_k_q];
    dc  = tpcb_pkg::NB_DC[rd_k_q];
    w_s = signed'((AW + 2)'(eff_w_q));
    off = (AW + 2)'(dc);
    if (dr == 2'sd1) begin
      off = w_s + (AW + 2)'(dc);
    end else if (dr == -2'sd1) begin
      off = (AW + 2)'(dc) - w_s;
    end
    a_sum = signed'((AW + 2)'(out_addr_q)) + off;
    if (a_sum < 0) begin
      a_sum = a_sum + signed'((AW + 2)'(RING));
    end else if (a_sum >= signed'((AW + 2)'(RING))) begin
      a_sum = a_sum - signed'((AW + 2)'(RING));
    end
    rd_addr = AW'(a_sum);
    incl = 1'b1;
    if (dr == -2'sd1 && out_row_q == '0) incl = 1'b0;
    if (dr == 2'sd1 && (HW + 1)'(out_row_q) + (HW + 1)'(1) >= (HW + 1)'(eff_h_q)) incl = 1'b0;
    if (dc == -2'sd1 && out_col_q == '0) incl = 1'b0;
    if (dc == 2'sd1 && (WW + 1)'(out_col_q) + (WW + 1)'(1) >= (WW + 1)'(eff_w_q)) incl = 1'b0;
    // taps ahead of the output must already have arrived
    if (off > 0 && (PW + 1)'(off) >= (PW + 1)'(pdiff)) incl = 1'b0;
  end

  always_comb begin
    tag_d.vld    = state_q == tpcb_pkg::ST_READ;
    tag_d.incl   = incl;
    tag_d.center = rd_k_q == tpcb_pkg::NB_CENTER;
  end

  tpcb_ring_mem #(
    .DEPTH (RING),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (take_pix),
    .waddr_i (in_addr_q),
    .wdata_i ({alpha_in_i, blue_in_i, green_in_i, red_in_i}),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // window sums from the ring read data
  always_ff @(posedge clk_i) begin
    if (emit) begin
      sr_q <= '0;
      sg_q <= '0;
      sb_q <= '0;
      sa_q <= '0;
    end else if (tag_q.vld) begin
      if (tag_q.center) begin
        ctr_q <= rdata;
      end else if (tag_q.incl) begin
        sr_q <= sr_q + tpcb_pkg::SUM_W'(rdata[7:0]);
        sg_q <= sg_q + tpcb_pkg::SUM_W'(rdata[15:8]);
        sb_q <= sb_q + tpcb_pkg::SUM_W'(rdata[23:16]);
        sa_q <= sa_q + tpcb_pkg::SUM_W'(rdata[31:24]);
      end
    end
  end

  tpcb_div u_div_r (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (state_q == tpcb_pkg::ST_DSTART),
    .sum_i (sr_q), .den_i (sa_q), .busy_o (div_busy[0]), .quot_o (qr)
  );
  tpcb_div u_div_g (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (state_q == tpcb_pkg::ST_DSTART),
    .sum_i (sg_q), .den_i (sa_q), .busy_o (div_busy[1]), .quot_o (qg)
  );
  tpcb_div u_div_b (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (state_q == tpcb_pkg::ST_DSTART),
    .sum_i (sb_q), .den_i (sa_q), .busy_o (div_busy[2]), .quot_o (qb)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpcb_pkg::ST_IDLE:   if (emit) state_d = tpcb_pkg::ST_READ;
      tpcb_pkg::ST_READ:   if (rd_k_q == tpcb_pkg::NB_CENTER) state_d = tpcb_pkg::ST_SUM;
      tpcb_pkg::ST_SUM:    state_d = tpcb_pkg::ST_DSTART;
      tpcb_pkg::ST_DSTART: state_d = tpcb_pkg::ST_DIV;
      tpcb_pkg::ST_DIV:    if (div_busy == '0) state_d = tpcb_pkg::ST_HOLD;
      tpcb_pkg::ST_HOLD:   if (out_ld) state_d = tpcb_pkg::ST_IDLE;
      default:             state_d = tpcb_pkg::ST_IDLE;
    endcase
  end

  assign out_ld    = (state_q == tpcb_pkg::ST_HOLD) && (!out_valid_q || out_ready_i);
  assign frame_end = (PW + 1)'(out_pos_q) + (PW + 1)'(1) >= (PW + 1)'(wh_q);
  assign chg       = (ctr_q[31:24] <= thr_q) && (sa_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpcb_pkg::ST_IDLE;
      rd_k_q      <= '0;
      tag_q       <= '0;
      in_pos_q    <= '0;
      out_pos_q   <= '0;
      in_addr_q   <= '0;
      out_addr_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tag_q   <= tag_d;
      if (state_q == tpcb_pkg::ST_READ && rd_k_q != tpcb_pkg::NB_CENTER) begin
        rd_k_q <= rd_k_q + 4'd1;
      end else begin
        rd_k_q <= '0;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (size_wr) begin
        in_pos_q   <= '0;
        out_pos_q  <= '0;
        in_addr_q  <= '0;
        out_addr_q <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
      end else begin
        if (take_pix) begin
          in_pos_q  <= in_pos_q + PW'(1);
          in_addr_q <= (in_addr_q == AW'(RING - 1)) ? '0 : in_addr_q + AW'(1);
        end
        if (out_ld) begin
          if (frame_end) begin
            in_pos_q   <= '0;
            out_pos_q  <= '0;
            in_addr_q  <= '0;
            out_addr_q <= '0;
            out_col_q  <= '0;
            out_row_q  <= '0;
          end else begin
            out_pos_q  <= out_pos_q + PW'(1);
            out_addr_q <= (out_addr_q == AW'(RING - 1)) ? '0 : out_addr_q + AW'(1);
            if ((WW + 1)'(out_col_q) + (WW + 1)'(1) >= (WW + 1)'(eff_w_q)) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + HW'(1);
            end else begin
              out_col_q <= out_col_q + WW'(1);
            end
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      red_out_o   <= chg ? qr : ctr_q[7:0];
      green_out_o <= chg ? qg : ctr_q[15:8];
      blue_out_o  <= chg ? qb : ctr_q[23:16];
      alpha_out_o <= ctr_q[31:24];
      changed_o   <= chg;
      last_o      <= frame_end;
    end
  end

  assign out_valid_o = out_valid_q;

  `TPCB_ASSERT_ALWAYS(a_out_behind_in, out_pos_q <= in_pos_q, "output position passed input")
  `TPCB_ASSERT_ALWAYS(a_addr_range, (in_addr_q < AW'(RING)) && (out_addr_q < AW'(RING)), "ring address out of range")
  `TPCB_ASSERT_NEXT(a_div_start, state_q == tpcb_pkg::ST_DSTART, div_busy == 3'b111, "dividers did not start")
  `TPCB_ASSERT_NEXT(a_emit_read, in_acc && emit, state_q == tpcb_pkg::ST_READ, "emit did not start reads")

endmodule
